>>> design/sdcwc_pkg.sv
// ============================================================================
// sdcwc_pkg
// Types, command codes, flag table and clock constants for the SD command
// word composer.
// ============================================================================
package sdcwc_pkg;

    // Widths
    localparam int EXT_W   = 30;          // base clock register
    localparam int DSR_W   = 27;          // 2*f fits below 2^27
    localparam int REM_W   = DSR_W + 1;
    localparam int QUO_W   = EXT_W;
    localparam int DQ_W    = 11;          // quotient never exceeds 1342
    localparam int PROD_W  = DQ_W + DSR_W;
    localparam int DIVO_W  = 10;
    localparam int STEP_W  = 5;
    localparam int DIV_STEPS = EXT_W;

    localparam logic [EXT_W-1:0] EXT_RESET = 30'd100000000;
    localparam logic [DIVO_W-1:0] DIV_MAX  = 10'd1023;

    // Twice the target clock for each mode, and twice (target + 1)
    localparam logic [DSR_W-1:0] F2_INIT  = 27'd800000;
    localparam logic [DSR_W-1:0] F2_STD   = 27'd50000000;
    localparam logic [DSR_W-1:0] F2_HS    = 27'd100000000;
    localparam logic [DSR_W-1:0] F2P_INIT = 27'd800002;
    localparam logic [DSR_W-1:0] F2P_STD  = 27'd50000002;
    localparam logic [DSR_W-1:0] F2P_HS   = 27'd100000002;

    // Clock modes
    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_STD  = 2'd1;
    localparam logic [1:0] MODE_HS   = 2'd2;

    // Command indexes with side effects
    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SWITCH    = 6'd6;
    localparam logic [5:0] CMD_SELECT    = 6'd7;
    localparam logic [5:0] CMD_IO_DIRECT = 6'd52;
    localparam logic [5:0] CMD_IO_EXT    = 6'd53;
    localparam logic [5:0] CMD_APP       = 6'd55;

    // Argument patterns
    localparam logic [31:0] HS_MASK     = 32'h8000000F;
    localparam logic [31:0] HS_MATCH    = 32'h80000001;
    localparam logic [31:0] BUSREG_MASK = 32'hFFFFFF00;
    localparam logic [31:0] BUSREG_ADDR = 32'h80000E00;
    localparam logic [31:0] ARG_W1      = 32'd0;
    localparam logic [31:0] ARG_W4      = 32'd2;
    localparam logic [1:0]  IOW_1       = 2'd0;
    localparam logic [1:0]  IOW_4       = 2'd2;

    // Command word flags
    localparam logic [31:0] W_ISDATA = 32'h0020_0000;
    localparam logic [31:0] W_IXCHK  = 32'h0010_0000;
    localparam logic [31:0] W_CRCCHK = 32'h0008_0000;
    localparam logic [31:0] W_R136   = 32'h0001_0000;
    localparam logic [31:0] W_R48    = 32'h0002_0000;
    localparam logic [31:0] W_R48B   = 32'h0003_0000;
    localparam logic [31:0] W_MULTI  = 32'h0000_0020;
    localparam logic [31:0] W_C2H    = 32'h0000_0010;
    localparam logic [31:0] W_BCEN   = 32'h0000_0002;
    localparam logic [31:0] W_CHK    = W_IXCHK | W_CRCCHK;

    typedef struct packed {
        logic [5:0]  cmd_num;
        logic [31:0] argument;
        logic [15:0] block_count;
    } cmd_in_t;

    typedef struct packed {
        logic [31:0]       command_word;
        logic              command_illegal;
        logic              wide_bus;
        logic [DIVO_W-1:0] clock_divider;
        logic              divider_saturated;
        logic              clock_changed;
    } cmd_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } seq_state_t;

    // Response type and check flags; zero marks an illegal index
    function automatic logic [31:0] flag_info(input logic [5:0] idx);
        logic [31:0] f;
        f = 32'd0;
        case (idx)
            6'd0:    f = W_IXCHK;
            6'd2:    f = W_R136;
            6'd3:    f = W_R48 | W_CHK;
            6'd5:    f = W_R48;
            6'd6:    f = W_R48 | W_CHK;
            6'd7:    f = W_R48B | W_CHK;
            6'd8:    f = W_R48 | W_CHK;
            6'd9:    f = W_R136;
            6'd11:   f = W_R48 | W_CHK;
            6'd12:   f = W_R48B | W_CHK;
            6'd13:   f = W_R48 | W_CHK;
            6'd16:   f = W_R48;
            6'd17:   f = W_R48 | W_ISDATA | W_C2H | W_CHK;
            6'd18:   f = W_R48 | W_ISDATA | W_C2H | W_MULTI | W_BCEN | W_CHK;
            6'd24:   f = W_R48 | W_ISDATA | W_CHK;
            6'd25:   f = W_R48 | W_ISDATA | W_MULTI | W_BCEN | W_CHK;
            6'd41:   f = W_R48;
            6'd52:   f = W_R48 | W_CHK;
            6'd53:   f = W_R48 | W_CHK | W_ISDATA;
            6'd55:   f = W_R48 | W_CHK;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

    function automatic logic [DSR_W-1:0] mode_f2(input logic [1:0] mode);
        logic [DSR_W-1:0] v;
        case (mode)
            MODE_STD: v = F2_STD;
            MODE_HS:  v = F2_HS;
            default:  v = F2_INIT;
        endcase
        return v;
    endfunction

    function automatic logic [DSR_W-1:0] mode_f2p(input logic [1:0] mode);
        logic [DSR_W-1:0] v;
        case (mode)
            MODE_STD: v = F2P_STD;
            MODE_HS:  v = F2P_HS;
            default:  v = F2P_INIT;
        endcase
        return v;
    endfunction

endpackage

>>> design/sd_command_word_composer_unit.sv
// ============================================================================
// sd_command_word_composer_unit
// Composes the SD command/transfer word, tracks bus width, app prefix and
// clock mode, and derives the SD clock divider.
// ============================================================================
// Sequence: command acceptance, 30 restoring divider steps, one multiply step,
//   then a finish step that waits for a free output register and sets rsp_valid.
// One command at a time: the shared one-bit-per-cycle divider is busy and
//   cmd_ready stays low from acceptance until the response is loaded.
// Reset (rst_n low, asynchronous): one-line bus, 400 kHz mode, no app prefix,
//   base clock 100 MHz, no response pending.
module sd_command_word_composer_unit
    import sdcwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_in_t          cmd,
    // response channel
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output cmd_out_t         rsp,
    // base clock register
    input  logic             cfg_we,
    input  logic [EXT_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    seq_state_t        state_reg, state_next;
    logic              app_reg, app_next;
    logic              bus_reg, bus_next;
    logic [1:0]        mode_reg, mode_next;
    logic [EXT_W-1:0]  ext_reg;

    // per-command payload, no reset needed
    logic [31:0]       word_reg, word_next;
    logic              illegal_reg, illegal_next;
    logic              changed_reg, changed_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    cmd_out_t          rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // ------------------------------------------------------------------
    // Command decode, evaluated on the accepting edge
    // ------------------------------------------------------------------
    logic        accept;
    logic [31:0] info;
    logic        legal;
    logic [31:0] dec_word;
    logic [1:0]  dec_mode;
    logic        dec_bus;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign info      = flag_info(cmd.cmd_num);
    assign legal     = (info != 32'd0);

    always_comb
    begin
        dec_word = {2'b00, cmd.cmd_num, 24'd0} | info;
        dec_mode = mode_reg;
        dec_bus  = bus_reg;
        // CMD6 without the app prefix is the function switch and reads a
        // status block
        if (cmd.cmd_num == CMD_SWITCH && !app_reg)
            dec_word = dec_word | W_ISDATA | W_C2H;
        // CMD53: direction from the R/W flag, multiblock unless one block
        if (cmd.cmd_num == CMD_IO_EXT)
        begin
            if (!cmd.argument[31])
                dec_word = dec_word | W_C2H;
            if (cmd.block_count != 16'd1)
                dec_word = dec_word | W_MULTI | W_BCEN;
        end
        if (cmd.cmd_num == CMD_GO_IDLE)
        begin
            dec_bus  = 1'b0;
            dec_mode = MODE_INIT;
        end
        if (cmd.cmd_num == CMD_SELECT)
            dec_mode = MODE_STD;
        if (cmd.cmd_num == CMD_SWITCH)
        begin
            if (app_reg)
            begin
                // ACMD6 bus width; other codes leave it alone
                if (cmd.argument == ARG_W1)
                    dec_bus = 1'b0;
                else if (cmd.argument == ARG_W4)
                    dec_bus = 1'b1;
            end
            else if ((cmd.argument & HS_MASK) == HS_MATCH)
            begin
                dec_mode = MODE_HS;
            end
        end
        else if (cmd.cmd_num == CMD_IO_DIRECT
                 && (cmd.argument & BUSREG_MASK) == BUSREG_ADDR)
        begin
            // CMD52 write to CCCR bus interface control
            if (cmd.argument[1:0] == IOW_1)
                dec_bus = 1'b0;
            else if (cmd.argument[1:0] == IOW_4)
                dec_bus = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider datapath: quo_reg shifts the dividend out at the top
    // and the quotient bits in at the bottom.
    // ------------------------------------------------------------------
    logic [DSR_W-1:0]  divisor;
    logic [REM_W-1:0]  trial;
    logic              fits;
    logic              round_up;
    logic [DQ_W:0]     div_full;

    assign divisor  = mode_f2(mode_reg);
    assign trial    = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};
    assign fits     = (trial >= {1'b0, divisor});

    // raise by one when the quotient is zero or ext/(2d) > f,
    // i.e. ext >= 2d(f+1)
    assign round_up = (quo_reg == '0)
                   || ({{(PROD_W-EXT_W){1'b0}}, ext_reg} >= prod_reg);
    assign div_full = {1'b0, quo_reg[DQ_W-1:0]} + {{DQ_W{1'b0}}, round_up};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        app_next       = app_reg;
        bus_next       = bus_reg;
        mode_next      = mode_reg;
        word_next      = word_reg;
        illegal_next   = illegal_reg;
        changed_next   = changed_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    illegal_next = !legal;
                    if (legal)
                    begin
                        word_next    = dec_word;
                        app_next     = (cmd.cmd_num == CMD_APP);
                        bus_next     = dec_bus;
                        mode_next    = dec_mode;
                        changed_next = (dec_mode != mode_reg);
                    end
                    else
                    begin
                        word_next    = 32'd0;
                        changed_next = 1'b0;
                    end
                    rem_next   = '0;
                    quo_next   = ext_reg;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? (trial - {1'b0, divisor}) : trial;
                quo_next  = {quo_reg[QUO_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = quo_reg[DQ_W-1:0] * mode_f2p(mode_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // load the output register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.command_word      = word_reg;
                    rsp_next.command_illegal   = illegal_reg;
                    rsp_next.wide_bus          = bus_reg;
                    rsp_next.clock_changed     = changed_reg;
                    if (div_full[DQ_W:DIVO_W] != '0)
                    begin
                        rsp_next.clock_divider     = DIV_MAX;
                        rsp_next.divider_saturated = 1'b1;
                    end
                    else
                    begin
                        rsp_next.clock_divider     = div_full[DIVO_W-1:0];
                        rsp_next.divider_saturated = 1'b0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            app_reg       <= 1'b0;
            bus_reg       <= 1'b0;
            mode_reg      <= MODE_INIT;
            rsp_valid_reg <= 1'b0;
            ext_reg       <= EXT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            app_reg       <= app_next;
            bus_reg       <= bus_next;
            mode_reg      <= mode_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
                ext_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        illegal_reg <= illegal_next;
        changed_reg <= changed_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        prod_reg    <= prod_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/sdcwc_checker.sv
// ============================================================================
// sdcwc_checker
// Port-level checks for the SD command word composer.
// ============================================================================
module sdcwc_checker
    import sdcwc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input cmd_out_t         rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // the divider holds cmd_ready low once a command is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready ##1 !cmd_ready)
        else $error("command taken while divider busy");

    // an illegal index yields an empty word and no clock change
    a_illegal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.command_illegal |->
            rsp.command_word == 32'd0 && !rsp.clock_changed)
        else $error("illegal command carries a word");

    // clamped divider reads full scale, never zero
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.clock_divider != '0
            && (!rsp.divider_saturated || rsp.clock_divider == DIV_MAX))
        else $error("bad clock divider");

endmodule

bind sd_command_word_composer_unit sdcwc_checker u_sdcwc_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the SD command word composer. Commands go in over
// the valid/ready command channel. A local model of the flag table, the
// prefix, bus-width and clock-mode tracking and the divider rounding predicts
// every response. The response channel is checked field by field, in order.
// ============================================================================
module tb
    import sdcwc_pkg::*;
();

    // Target SD clock frequency of each mode, in Hz
    localparam longint unsigned HZ_INIT = 64'd400000;
    localparam longint unsigned HZ_STD  = 64'd25000000;
    localparam longint unsigned HZ_HS   = 64'd50000000;

    // Base clock register legal span
    localparam logic [EXT_W-1:0] EXT_LOW  = 30'd1000000;
    localparam logic [EXT_W-1:0] EXT_HIGH = 30'd1000000000;

    // Cycles to let pass after the last response before touching the register
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 190;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_ready;
    cmd_in_t          cmd = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    cmd_out_t         rsp;
    logic             cfg_we = 1'b0;
    logic [EXT_W-1:0] cfg_data = EXT_RESET;

    // Predicted responses, oldest first
    cmd_out_t expected_rsps[$];
    // Commands planned by the random generator, waiting to be sent
    cmd_in_t  planned_cmds[$];

    int errors = 0;

    // Traffic shaping: per-cycle odds (percent) of an idle/stall cycle
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    // Requested length of a forced receiver hold-off; taken by the receiver
    int hold_len = 0;

    // Model state
    logic [EXT_W-1:0] mdl_ext_hz;
    logic             mdl_app_pending;
    logic             mdl_wide;
    logic [1:0]       mdl_mode;

    sd_command_word_composer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Response type and check flags per index; zero means no such command
    function automatic logic [31:0] cmd_flags(input logic [5:0] idx);
        logic [31:0] fl;
        case (idx)
            6'd0:    fl = W_IXCHK;
            6'd2,
            6'd9:    fl = W_R136;
            6'd5,
            6'd16,
            6'd41:   fl = W_R48;
            6'd3, 6'd6, 6'd8, 6'd11, 6'd13, 6'd52, 6'd55:
                     fl = W_R48 | W_CHK;
            6'd7,
            6'd12:   fl = W_R48B | W_CHK;
            6'd17:   fl = W_R48 | W_CHK | W_ISDATA | W_C2H;
            6'd18:   fl = W_R48 | W_CHK | W_ISDATA | W_C2H | W_MULTI | W_BCEN;
            6'd24:   fl = W_R48 | W_CHK | W_ISDATA;
            6'd25:   fl = W_R48 | W_CHK | W_ISDATA | W_MULTI | W_BCEN;
            6'd53:   fl = W_R48 | W_CHK | W_ISDATA;
            default: fl = 32'd0;
        endcase
        return fl;
    endfunction

    // {saturated, divider} for a clock mode at the current base clock.
    // Rounds up when ext/(2d) still exceeds the target; a zero quotient
    // always rounds up to 1.
    function automatic logic [DIVO_W:0] sd_clock_divider(input logic [1:0] mode);
        longint unsigned f_hz;
        longint unsigned e_hz;
        longint unsigned d;
        logic            sat;
        case (mode)
            MODE_STD: f_hz = HZ_STD;
            MODE_HS:  f_hz = HZ_HS;
            default:  f_hz = HZ_INIT;
        endcase
        e_hz = longint'(mdl_ext_hz);
        d = e_hz / (2 * f_hz);
        if (d == 0 || e_hz / (2 * d) > f_hz)
            d = d + 1;
        sat = 1'b0;
        if (d > 1023)
        begin
            d = 1023;
            sat = 1'b1;
        end
        return {sat, d[DIVO_W-1:0]};
    endfunction

    // Predict one response and advance the model state
    function automatic cmd_out_t compose_expected(input cmd_in_t c);
        cmd_out_t    r;
        logic [31:0] info;
        logic [1:0]  prev_mode;
        info = cmd_flags(c.cmd_num);
        prev_mode = mdl_mode;
        r = '0;
        if (info == 32'd0)
        begin
            // unknown index: flagged, nothing else moves (prefix included)
            r.command_illegal = 1'b1;
        end
        else
        begin
            r.command_word = {2'b00, c.cmd_num, 24'd0} | info;
            if (c.cmd_num == CMD_SWITCH && !mdl_app_pending)
                r.command_word = r.command_word | W_ISDATA | W_C2H;
            if (c.cmd_num == CMD_IO_EXT)
            begin
                if (!c.argument[31])
                    r.command_word = r.command_word | W_C2H;
                if (c.block_count != 16'd1)
                    r.command_word = r.command_word | W_MULTI | W_BCEN;
            end
            case (c.cmd_num)
                CMD_GO_IDLE:
                begin
                    mdl_wide = 1'b0;
                    mdl_mode = MODE_INIT;
                end
                CMD_SELECT:
                    mdl_mode = MODE_STD;
                CMD_SWITCH:
                begin
                    if (mdl_app_pending)
                    begin
                        if (c.argument == ARG_W1)
                            mdl_wide = 1'b0;
                        else if (c.argument == ARG_W4)
                            mdl_wide = 1'b1;
                    end
                    else if ((c.argument & HS_MASK) == HS_MATCH)
                        mdl_mode = MODE_HS;
                end
                CMD_IO_DIRECT:
                begin
                    if ((c.argument & BUSREG_MASK) == BUSREG_ADDR)
                    begin
                        if (c.argument[1:0] == IOW_1)
                            mdl_wide = 1'b0;
                        else if (c.argument[1:0] == IOW_4)
                            mdl_wide = 1'b1;
                    end
                end
                default: ;
            endcase
            mdl_app_pending = (c.cmd_num == CMD_APP);
            r.clock_changed = (mdl_mode != prev_mode);
        end
        r.wide_bus = mdl_wide;
        {r.divider_saturated, r.clock_divider} = sd_clock_divider(mdl_mode);
        return r;
    endfunction

    function automatic cmd_in_t mk_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                       input logic [15:0] cnt);
        cmd_in_t c;
        c.cmd_num = idx;
        c.argument = arg;
        c.block_count = cnt;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offer one command transaction; returns after the accepting edge.
    // Valid is only lowered during idle cycles, so it never drops and rises
    // in the same time step.
    task automatic send_cmd(input cmd_in_t c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        expected_rsps.push_back(compose_expected(c));
    endtask

    // Stop offering and wait until every predicted response has come back,
    // then let the block settle.
    task automatic drain_responses();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the base clock register while the block is idle
    task automatic set_base_clock(input logic [EXT_W-1:0] hz);
        drain_responses();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= hz;
        @(negedge clk);
        cfg_we <= 1'b0;
        mdl_ext_hz = hz;
    endtask

    // Receiver: random stalls, plus a forced hold-off counted here in cycles
    always @(negedge clk)
    begin : receiver
        int hold_left;
        if (hold_len != 0)
        begin
            hold_left = hold_len;
            hold_len = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%08h actual 0x%08h",
                     $time, name, want, got);
        end
    endtask

    // Response checker: every accepted response against the oldest prediction
    always @(posedge clk)
    begin : rsp_checker
        cmd_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response: expected none actual 0x%08h",
                         $time, rsp.command_word);
            end
            else
            begin
                want = expected_rsps.pop_front();
                report_field("command_word", want.command_word, rsp.command_word);
                report_field("command_illegal", 32'(want.command_illegal),
                             32'(rsp.command_illegal));
                report_field("wide_bus", 32'(want.wide_bus), 32'(rsp.wide_bus));
                report_field("clock_divider", 32'(want.clock_divider),
                             32'(rsp.clock_divider));
                report_field("divider_saturated", 32'(want.divider_saturated),
                             32'(rsp.divider_saturated));
                report_field("clock_changed", 32'(want.clock_changed),
                             32'(rsp.clock_changed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------

    // Base clock: half uniform, half built from some mode, mostly on a rounding edge.
    // With ext = 2*f*k + r the divider rounds up once r >= 2k.
    function automatic logic [EXT_W-1:0] pick_base_clock();
        longint unsigned f_hz;
        longint unsigned k;
        longint unsigned v;
        if ($urandom_range(1) == 0)
            return EXT_W'($urandom_range(EXT_HIGH, EXT_LOW));
        case ($urandom_range(2))
            0:       f_hz = HZ_INIT;
            1:       f_hz = HZ_STD;
            default: f_hz = HZ_HS;
        endcase
        k = longint'($urandom_range(1300, 1));
        v = 2 * f_hz * k;
        case ($urandom_range(3))
            0:       v = v;
            1:       v = v + 2 * k - 1;
            2:       v = v + 2 * k;
            default: v = v + longint'($urandom_range(32'(2 * f_hz - 1)));
        endcase
        if (v > EXT_HIGH)
            v = EXT_HIGH;
        if (v < EXT_LOW)
            v = EXT_LOW;
        return v[EXT_W-1:0];
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(5))
            0, 1:    return 16'd1;
            2:       return 16'd0;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue up one short command sequence: prefix + switch, high-speed switch,
    // I/O bus-width write, CMD53, CMD0 or CMD7, a broken prefix followed by any
    // index, or a plain random command, legal or not.
    task automatic plan_sequence();
        logic [31:0] r;
        logic [5:0]  idx;
        int          kind;
        r = $urandom;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            planned_cmds.push_back(mk_cmd(CMD_APP, $urandom, pick_count()));
            case ($urandom_range(3))
                0:       r = ARG_W1;
                1:       r = ARG_W4;
                2:       r = $urandom_range(3);
                default: r = r;
            endcase
            planned_cmds.push_back(mk_cmd(CMD_SWITCH, r, pick_count()));
        end
        else if (kind < 25)
        begin
            if ($urandom_range(1))
                r = (r & ~HS_MASK) | HS_MATCH;
            planned_cmds.push_back(mk_cmd(CMD_SWITCH, r, pick_count()));
        end
        else if (kind < 35)
        begin
            if ($urandom_range(3) != 0)
                r = BUSREG_ADDR | (r & ~BUSREG_MASK);
            planned_cmds.push_back(mk_cmd(CMD_IO_DIRECT, r, pick_count()));
        end
        else if (kind < 45)
            planned_cmds.push_back(mk_cmd(CMD_IO_EXT, r, pick_count()));
        else if (kind < 50)
            planned_cmds.push_back(mk_cmd(CMD_GO_IDLE, r, pick_count()));
        else if (kind < 55)
            planned_cmds.push_back(mk_cmd(CMD_SELECT, r, pick_count()));
        else if (kind < 65)
        begin
            // prefix followed by anything at all
            planned_cmds.push_back(mk_cmd(CMD_APP, $urandom, pick_count()));
            planned_cmds.push_back(mk_cmd(6'($urandom_range(63)), r, pick_count()));
        end
        else if (kind < 85)
        begin
            do
                idx = 6'($urandom_range(63));
            while (cmd_flags(idx) == 32'd0);
            planned_cmds.push_back(mk_cmd(idx, r, pick_count()));
        end
        else
            planned_cmds.push_back(mk_cmd(6'($urandom_range(63)), r, 16'($urandom)));
    endtask

    // One phase: set the base clock and traffic shape, then stream commands
    task automatic run_phase(input logic [EXT_W-1:0] hz, input int idle_pct,
                             input int stall_pct, input int n_items);
        int sent;
        set_base_clock(hz);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if (planned_cmds.size() == 0)
                plan_sequence();
            send_cmd(planned_cmds.pop_front());
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // After reset: CMD0 keeps 400 kHz (no change flagged); unknown indexes
    // at both ends of the field
    task automatic test_reset_defaults();
        send_cmd(mk_cmd(CMD_GO_IDLE, 32'd0, 16'd0));
        send_cmd(mk_cmd(6'd1, 32'd0, 16'd1));
        send_cmd(mk_cmd(6'd63, 32'hFFFF_FFFF, 16'hFFFF));
    endtask

    // Application prefix: ACMD6 width codes, prefix surviving an unknown
    // index, other width codes, and plain CMD6 switching to high speed
    task automatic test_app_prefix_width();
        send_cmd(mk_cmd(CMD_APP, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SWITCH, ARG_W4, 16'd1));
        send_cmd(mk_cmd(CMD_APP, 32'hFFFF_FFFF, 16'd1));
        send_cmd(mk_cmd(6'd63, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SWITCH, ARG_W1, 16'd1));
        send_cmd(mk_cmd(CMD_APP, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SWITCH, 32'd1, 16'd1));
        send_cmd(mk_cmd(CMD_SWITCH, HS_MATCH, 16'd1));
    endtask

    // Clock modes: select to standard, CMD0 back to 400 kHz, high speed
    task automatic test_clock_modes();
        send_cmd(mk_cmd(CMD_SELECT, 32'h1234_0000, 16'd1));
        send_cmd(mk_cmd(CMD_GO_IDLE, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SWITCH, 32'h8FFF_FFF1, 16'd1));
    endtask

    // CMD52 to the bus-width register with every low-bit code, and CMD53
    // direction and block-count handling
    task automatic test_io_commands();
        send_cmd(mk_cmd(CMD_IO_DIRECT, BUSREG_ADDR | 32'd2, 16'd1));
        send_cmd(mk_cmd(CMD_IO_DIRECT, BUSREG_ADDR | 32'd1, 16'd1));
        send_cmd(mk_cmd(CMD_IO_DIRECT, BUSREG_ADDR | 32'd3, 16'd1));
        send_cmd(mk_cmd(CMD_IO_DIRECT, BUSREG_ADDR, 16'd1));
        send_cmd(mk_cmd(CMD_IO_EXT, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_IO_EXT, 32'h8000_0000, 16'd0));
        send_cmd(mk_cmd(CMD_IO_EXT, 32'hFFFF_FFFF, 16'hFFFF));
    endtask

    // Base clock at its extremes: at the low end the fast modes have a zero
    // quotient, at the high end the 400 kHz divider saturates
    task automatic test_divider_extremes();
        set_base_clock(EXT_LOW);
        send_cmd(mk_cmd(CMD_GO_IDLE, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SELECT, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SWITCH, HS_MATCH, 16'd1));
        set_base_clock(EXT_HIGH);
        send_cmd(mk_cmd(CMD_GO_IDLE, 32'd0, 16'd1));
        send_cmd(mk_cmd(CMD_SELECT, 32'd0, 16'd1));
    endtask

    // Random traffic across the four traffic shapes and several base clocks
    task automatic test_random_traffic();
        run_phase(EXT_RESET,         0,  0,  ITEMS_PER_PHASE);
        run_phase(EXT_LOW,           52, 0,  ITEMS_PER_PHASE);
        run_phase(EXT_HIGH,          0,  52, ITEMS_PER_PHASE);
        run_phase(pick_base_clock(), 18, 18, ITEMS_PER_PHASE);
        run_phase(pick_base_clock(), 0,  0,  ITEMS_PER_PHASE);
        run_phase(pick_base_clock(), 52, 0,  ITEMS_PER_PHASE);
        run_phase(pick_base_clock(), 0,  52, ITEMS_PER_PHASE);
        run_phase(pick_base_clock(), 18, 18, ITEMS_PER_PHASE);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and backs up the command channel
    task automatic test_backpressure();
        int i;
        drain_responses();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_len = 400;
        for (i = 0; i < 16; i++)
        begin
            if (planned_cmds.size() == 0)
                plan_sequence();
            send_cmd(planned_cmds.pop_front());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mdl_ext_hz = EXT_RESET;
        mdl_app_pending = 1'b0;
        mdl_wide = 1'b0;
        mdl_mode = MODE_INIT;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_app_prefix_width();
        test_clock_modes();
        test_io_commands();
        test_divider_extremes();
        test_random_traffic();
        test_backpressure();
        drain_responses();

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule
